FILE: rtl/hsl2rgb_pkg.sv
`default_nettype none

package hsl2rgb_pkg;

  // Q16 unsigned inputs, 65536 stands for 1.0
  localparam int W_IN   = 17;
  localparam int W_HP   = 19;   // six times hue, up to 6.0
  localparam int W_C    = 33;   // chroma in Q32, up to 1.0
  localparam int W_CMP  = 49;   // chroma and intermediate in Q48
  localparam int W_SUM  = 51;   // signed channel sum in Q48
  localparam int W_SCL  = 58;   // sum times 255
  localparam int W_CH   = 8;

  localparam logic [W_IN-1:0] ONE_Q16 = 17'h10000;

  typedef logic [2:0] sext_t;

  localparam sext_t SEXT_RED_YEL   = 3'd0;
  localparam sext_t SEXT_YEL_GRN   = 3'd1;
  localparam sext_t SEXT_GRN_CYN   = 3'd2;
  localparam sext_t SEXT_CYN_BLU   = 3'd3;
  localparam sext_t SEXT_BLU_MAG   = 3'd4;
  localparam sext_t SEXT_MAG_RED   = 3'd5;

  typedef logic signed [W_SUM-1:0] sum_t;

endpackage

`default_nettype wire

FILE: rtl/hsl_to_rgb_converter_core.sv
// Channel  | Dir | Width | Content (lowest bit first)
// s_axis   | in  | 56    | hue[16:0], saturation[33:17], lightness[50:34], zero fill
// m_axis   | out | 24    | red[7:0], green[15:8], blue[23:16]
//
// Five register stages; an accepted word moves through stages 1 to 5 in order, and
// m_tvalid is the valid bit of stage 5. One word per cycle is sustained while m_tready
// stays high; the heaviest stage is the 33 x 17 multiply forming the intermediate term.
// Each stage advances when it is empty or the next one advances, so bubbles
// collapse and a new word enters while a finished word waits at the output.
// rst (synchronous) clears only the stage valid bits; payload is left as is.
`default_nettype none

module hsl_to_rgb_converter_core
  import hsl2rgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [55:0] s_tdata,   // hue, saturation, lightness, zero fill
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata    // red, green, blue
);

  // stage valid bits and the per-stage advance conditions
  logic [4:0] vld;
  logic [4:0] rdy;

  always_comb begin
    rdy[4] = !vld[4] || m_tready;
    rdy[3] = !vld[3] || rdy[4];
    rdy[2] = !vld[2] || rdy[3];
    rdy[1] = !vld[1] || rdy[2];
    rdy[0] = !vld[0] || rdy[1];
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: saturate inputs to 1.0, fold lightness and the hue sextant
  // ---------------------------------------------------------------------
  logic [W_IN-1:0] hue_c, sat_c, lgt_c;
  logic [W_IN:0]   two_l;
  logic [W_IN-1:0] dist_l, omd;
  logic [W_HP-1:0] hp;
  logic [W_IN-1:0] frac2, dist_h, ofd;
  sext_t           sext_raw;

  always_comb begin
    hue_c = s_tdata[16] ? ONE_Q16 : s_tdata[16:0];
    sat_c = s_tdata[33] ? ONE_Q16 : s_tdata[33:17];
    lgt_c = s_tdata[50] ? ONE_Q16 : s_tdata[50:34];

    // 1 - |2L - 1|
    two_l = {lgt_c, 1'b0};
    if (two_l >= {1'b0, ONE_Q16}) begin
      dist_l = W_IN'(two_l - {1'b0, ONE_Q16});
    end else begin
      dist_l = W_IN'({1'b0, ONE_Q16} - two_l);
    end
    omd = ONE_Q16 - dist_l;

    // six times hue: integer part picks the sextant, modulo 2.0 feeds X
    hp = {hue_c, 2'b00} + {1'b0, hue_c, 1'b0};
    sext_raw = hp[W_HP-1:16];
    if (sext_raw > SEXT_MAG_RED) begin
      sext_raw = SEXT_MAG_RED;
    end
    frac2 = hp[W_IN-1:0];
    if (frac2 >= ONE_Q16) begin
      dist_h = frac2 - ONE_Q16;
    end else begin
      dist_h = ONE_Q16 - frac2;
    end
    ofd = ONE_Q16 - dist_h;
  end

  logic [W_IN-1:0] s1_omd, s1_sat, s1_lgt, s1_ofd;
  sext_t           s1_sext;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_omd  <= omd;
      s1_sat  <= sat_c;
      s1_lgt  <= lgt_c;
      s1_ofd  <= ofd;
      s1_sext <= sext_raw;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: chroma = (1 - |2L - 1|) * S in Q32
  // ---------------------------------------------------------------------
  logic [W_C-1:0]  s2_c;
  logic [W_IN-1:0] s2_lgt, s2_ofd;
  sext_t           s2_sext;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_c    <= {1'b0, s1_omd} * {1'b0, s1_sat};
      s2_lgt  <= s1_lgt;
      s2_ofd  <= s1_ofd;
      s2_sext <= s1_sext;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: intermediate X, chroma and offset M, all in Q48
  // ---------------------------------------------------------------------
  logic [W_C+W_IN-1:0] xprod;
  logic [W_CMP-1:0]    s3_x, s3_c;
  sum_t                s3_m;
  sext_t               s3_sext;

  assign xprod = s2_c * s2_ofd;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_x    <= xprod[W_CMP-1:0];
      s3_c    <= {s2_c[W_CMP-17:0], 16'b0};
      // M = L - C/2
      s3_m    <= $signed({2'b00, s2_lgt, 32'b0}) - $signed({3'b000, s2_c, 15'b0});
      s3_sext <= s2_sext;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: route C and X by sextant, add the offset
  // ---------------------------------------------------------------------
  logic [W_CMP-1:0] r_cmp, g_cmp, b_cmp;
  sum_t             s4_r, s4_g, s4_b;

  always_comb begin
    r_cmp = '0;
    g_cmp = '0;
    b_cmp = '0;
    case (s3_sext)
      SEXT_RED_YEL: begin r_cmp = s3_c; g_cmp = s3_x; end
      SEXT_YEL_GRN: begin r_cmp = s3_x; g_cmp = s3_c; end
      SEXT_GRN_CYN: begin g_cmp = s3_c; b_cmp = s3_x; end
      SEXT_CYN_BLU: begin g_cmp = s3_x; b_cmp = s3_c; end
      SEXT_BLU_MAG: begin r_cmp = s3_x; b_cmp = s3_c; end
      default:      begin r_cmp = s3_c; b_cmp = s3_x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_r <= $signed({2'b00, r_cmp}) + s3_m;
      s4_g <= $signed({2'b00, g_cmp}) + s3_m;
      s4_b <= $signed({2'b00, b_cmp}) + s3_m;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: scale by 255, truncate, saturate to 0..255
  // ---------------------------------------------------------------------
  // A positive sum stays below 2^50, so only the final compare can clip high.
  function automatic logic [W_CH-1:0] to_channel(input sum_t q);
    logic [W_SCL-1:0] p;
    logic [9:0]       v;
    p = {q[W_SUM-2:0], 8'b0} - {8'b0, q[W_SUM-2:0]};
    v = p[W_SCL-1:48];
    if (q[W_SUM-1] || q == '0) begin
      to_channel = '0;
    end else if (v > 10'd255) begin
      to_channel = 8'hFF;
    end else begin
      to_channel = v[W_CH-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      m_tdata <= {to_channel(s4_b), to_channel(s4_g), to_channel(s4_r)};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hsl2rgb_checker.sv
`default_nettype none

module hsl2rgb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [55:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // after reset the output stage holds no word
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an empty output stage lets every stage advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // input side never blocks while the output is being taken
  a_ready_when_taken: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |-> s_tready)
    else $error("input stalled while output drains");

endmodule

bind hsl_to_rgb_converter_core hsl2rgb_checker u_hsl2rgb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: test/hsl_to_rgb_converter_core_test.sv
`timescale 1ns / 100ps

module hsl_to_rgb_converter_core_test
  import hsl2rgb_pkg::*;
;

  localparam int PIPE_DEPTH = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_ERRORS = 10;
  localparam logic [63:0] UNIT = 64'd65536;

  // packed so that the layout matches m_tdata: red lowest, blue highest
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;

  rgb_t expected_rgb[$];
  int gap_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  hsl_to_rgb_converter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Anything above one counts as one.
  function automatic logic [63:0] limit_to_one(logic [W_IN-1:0] v);
    return (v > ONE_Q16) ? UNIT : 64'(v);
  endfunction

  // Scale a Q48 level by 255, truncate and saturate to a byte.
  function automatic logic [7:0] scale_channel(longint q48);
    longint scaled;
    if (q48 <= 0) return 8'd0;
    if (q48 > (64'sd1 <<< 50)) return 8'd255;
    scaled = (q48 * 255) >>> 48;
    return (scaled > 255) ? 8'd255 : scaled[7:0];
  endfunction

  // Exact integer HSL to RGB: chroma in Q32, components and offset in Q48.
  function automatic rgb_t predict_rgb(logic [W_IN-1:0] hue_in, logic [W_IN-1:0] sat_in,
                                       logic [W_IN-1:0] light_in);
    logic [63:0] h, s, l, light_gap, chroma, hue6, frac2, fold;
    longint c_q48, x_q48, offset, r, g, b;
    sext_t sext;
    rgb_t px;
    h = limit_to_one(hue_in);
    s = limit_to_one(sat_in);
    l = limit_to_one(light_in);
    light_gap = (2 * l >= UNIT) ? 2 * l - UNIT : UNIT - 2 * l;
    chroma = (UNIT - light_gap) * s;
    hue6 = 6 * h;
    frac2 = hue6 & 64'h1FFFF;
    fold = (frac2 >= UNIT) ? frac2 - UNIT : UNIT - frac2;
    c_q48 = longint'(chroma << 16);
    x_q48 = longint'(chroma * (UNIT - fold));
    offset = longint'(l << 32) - longint'(chroma << 15);
    // hue of exactly one lands on 6.0: hold it in the last sextant
    sext = ((hue6 >> 16) > 5) ? SEXT_MAG_RED : sext_t'(hue6 >> 16);
    r = 0;
    g = 0;
    b = 0;
    case (sext)
      SEXT_RED_YEL: begin r = c_q48; g = x_q48; end
      SEXT_YEL_GRN: begin r = x_q48; g = c_q48; end
      SEXT_GRN_CYN: begin g = c_q48; b = x_q48; end
      SEXT_CYN_BLU: begin g = x_q48; b = c_q48; end
      SEXT_BLU_MAG: begin r = x_q48; b = c_q48; end
      default:      begin r = c_q48; b = x_q48; end
    endcase
    px.red = scale_channel(r + offset);
    px.green = scale_channel(g + offset);
    px.blue = scale_channel(b + offset);
    return px;
  endfunction

  function automatic logic [W_IN-1:0] random_level();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE_Q16;
      2: return W_IN'($urandom_range(131071, 65537));
      default: return W_IN'($urandom_range(65536));
    endcase
  endfunction

  // Hue biased towards the sextant edges, where the fold changes direction.
  function automatic logic [W_IN-1:0] random_hue();
    int edge_idx;
    if ($urandom_range(3) == 0) begin
      edge_idx = $urandom_range(6);
      return W_IN'((edge_idx * 65536) / 6 + $urandom_range(2));
    end
    return random_level();
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Offer one word, with random idle cycles ahead of it, and note its colour.
  task automatic send_pixel(logic [W_IN-1:0] hue, logic [W_IN-1:0] sat,
                            logic [W_IN-1:0] light);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, light, sat, hue};
    do @(posedge clk); while (!s_tready);
    expected_rgb.push_back(predict_rgb(hue, sat, light));
  endtask

  // Hold the sender off until every outstanding word has come back.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_pixels(int count);
    repeat (count) send_pixel(random_hue(), random_level(), random_level());
  endtask

  task automatic test_corner_colours();
    gap_pct = 0;
    stall_pct = 0;
    send_pixel(17'd0, 17'd0, 17'd0);              // black
    send_pixel(17'd0, 17'd0, ONE_Q16);            // white
    send_pixel(17'd0, 17'd0, 17'd32768);          // grey, no saturation
    send_pixel(17'd0, ONE_Q16, 17'd32768);        // pure red
    send_pixel(17'd21845, ONE_Q16, 17'd32768);    // near pure green
    send_pixel(17'd43691, ONE_Q16, 17'd32768);    // near pure blue
    send_pixel(17'd5461, ONE_Q16, 17'd32768);     // middle of each sextant
    send_pixel(17'd16384, ONE_Q16, 17'd32768);
    send_pixel(17'd27307, ONE_Q16, 17'd32768);
    send_pixel(17'd38229, ONE_Q16, 17'd32768);
    send_pixel(17'd49152, ONE_Q16, 17'd32768);
    send_pixel(17'd60075, ONE_Q16, 17'd32768);
    send_pixel(17'd10922, ONE_Q16, 17'd32768);    // either side of a sextant edge
    send_pixel(17'd10923, ONE_Q16, 17'd32768);
    send_pixel(ONE_Q16, ONE_Q16, 17'd32768);      // hue of exactly one
    send_pixel(17'd65535, ONE_Q16, 17'd32768);
    send_pixel(17'd65537, 17'd65537, 17'd65537);  // just above one
    send_pixel(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);  // all bits set
    send_pixel(17'h1FFFF, ONE_Q16, 17'd16384);
    send_pixel(17'd30000, ONE_Q16, 17'd1);        // nearly black, full saturation
    send_pixel(17'd30000, ONE_Q16, 17'd65535);    // nearly white
    send_pixel(17'd12345, 17'd1, 17'd32768);
  endtask

  task automatic test_full_rate();
    gap_pct = 0;
    stall_pct = 0;
    send_random_pixels(132);
  endtask

  task automatic test_sender_gaps();
    gap_pct = 67;
    stall_pct = 0;
    send_random_pixels(66);
    wait_for_drain();
    send_random_pixels(66);
  endtask

  task automatic test_receiver_stalls();
    gap_pct = 0;
    stall_pct = 67;
    send_random_pixels(132);
  endtask

  task automatic test_both_idle();
    gap_pct = 19;
    stall_pct = 19;
    send_random_pixels(132);
  endtask

  // Randomly stall the output; stall_pct of zero keeps it always ready.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each delivered word with the oldest expected colour.
  always @(posedge clk) begin : check_output
    rgb_t want;
    rgb_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_rgb.size() == 0) begin
        report_error($sformatf("unexpected word r=%0d g=%0d b=%0d", got.red, got.green,
                               got.blue));
      end else begin
        want = expected_rgb.pop_front();
        if (got.red !== want.red)
          report_error($sformatf("red expected %0d got %0d", want.red, got.red));
        if (got.green !== want.green)
          report_error($sformatf("green expected %0d got %0d", want.green, got.green));
        if (got.blue !== want.blue)
          report_error($sformatf("blue expected %0d got %0d", want.blue, got.blue));
      end
    end
  end

  // Drop out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsl_to_rgb_converter_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_corner_colours();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    wait_for_drain();
    // allow a stray extra word time to surface
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (expected_rgb.size() != 0)
      report_error($sformatf("%0d words never delivered", expected_rgb.size()));
    if (error_count == 0) begin
      $display("hsl_to_rgb_converter_core test passed");
    end else begin
      $display("hsl_to_rgb_converter_core test failed");
    end
    $finish;
  end

endmodule

FILE: hsl_to_rgb_converter_core.f
rtl/hsl2rgb_pkg.sv
rtl/hsl_to_rgb_converter_core.sv
rtl/hsl2rgb_checker.sv
test/hsl_to_rgb_converter_core_test.sv
